>>> hdl/mmg_pkg.sv
// ----------------------------------------------------------------------------
// mmg_pkg: shared types and constants
// Field widths, command codes, mode codes and the MAC control word.
// ----------------------------------------------------------------------------
package mmg_pkg;

  localparam int FUNC_W    = 2;
  localparam int MODE_W    = 2;
  localparam int DIM_W     = 5;
  localparam int IDX_W     = 4;
  localparam int ELEM_W    = 16;
  localparam int VAL_W     = 32;
  localparam int CFG_IDX_W = 2;

  // command codes
  localparam logic [FUNC_W-1:0] FUNC_LOAD_FIRST  = 2'd0;
  localparam logic [FUNC_W-1:0] FUNC_LOAD_SECOND = 2'd1;
  localparam logic [FUNC_W-1:0] FUNC_QUERY       = 2'd2;

  // product modes
  localparam logic [MODE_W-1:0] MODE_FWD       = 2'd0;
  localparam logic [MODE_W-1:0] MODE_GRAD_LEFT = 2'd1;
  localparam logic [MODE_W-1:0] MODE_GRAD_RGHT = 2'd2;

  // register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_OP_MODE = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_DIM_M   = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_DIM_K   = 2'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_DIM_N   = 2'd3;

  localparam logic [DIM_W-1:0] DIM_RESET = 5'd16;

  typedef struct packed {
    logic start;  // load accumulator with the initial value
    logic step;   // operand pair valid on the store read ports
  } mac_ctrl_t;

endpackage

>>> hdl/mmg_store.sv
// ----------------------------------------------------------------------------
// mmg_store: operand store
// Synchronous RAM, one write port, one read port with registered data.
// ----------------------------------------------------------------------------
module mmg_store #(
  parameter int DEPTH = 256,
  parameter int AW    = 8
) (
  input  logic                      clk,
  input  logic                      we,
  input  logic [AW-1:0]             waddr,
  input  logic [mmg_pkg::ELEM_W-1:0] wdata,
  input  logic [AW-1:0]             raddr,
  output logic [mmg_pkg::ELEM_W-1:0] rdata
);

  logic [mmg_pkg::ELEM_W-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

>>> hdl/mmg_mac.sv
// ----------------------------------------------------------------------------
// mmg_mac: multiply-accumulate with output saturation
// Registered 16x16 product, wide accumulator, clip to signed 32 bits.
// ----------------------------------------------------------------------------
module mmg_mac #(
  parameter int ACC_W = 38
) (
  input  logic                             clk,
  input  logic                             rst,
  input  mmg_pkg::mac_ctrl_t               ctrl,
  input  logic signed [mmg_pkg::VAL_W-1:0]  init,
  input  logic signed [mmg_pkg::ELEM_W-1:0] a,
  input  logic signed [mmg_pkg::ELEM_W-1:0] b,
  output logic                             pending,
  output logic signed [mmg_pkg::VAL_W-1:0]  result,
  output logic                             sat
);

  localparam int VW = mmg_pkg::VAL_W;

  localparam logic signed [ACC_W-1:0] SAT_HI = {{(ACC_W-VW+1){1'b0}}, {(VW-1){1'b1}}};
  localparam logic signed [ACC_W-1:0] SAT_LO = {{(ACC_W-VW+1){1'b1}}, {(VW-1){1'b0}}};

  logic signed [VW-1:0]    prod;
  logic signed [ACC_W-1:0] acc;

  always_ff @(posedge clk) begin
    if (rst) begin
      pending <= 1'b0;
    end else begin
      pending <= ctrl.step;
    end
  end

  always_ff @(posedge clk) begin
    prod <= a * b;
    if (ctrl.start) begin
      acc <= {{(ACC_W-VW){init[VW-1]}}, init};
    end else if (pending) begin
      acc <= acc + {{(ACC_W-VW){prod[VW-1]}}, prod};
    end
  end

  always_comb begin
    if (acc > SAT_HI) begin
      result = SAT_HI[VW-1:0];
      sat    = 1'b1;
    end else if (acc < SAT_LO) begin
      result = SAT_LO[VW-1:0];
      sat    = 1'b1;
    end else begin
      result = acc[VW-1:0];
      sat    = 1'b0;
    end
  end

endmodule

>>> hdl/matrix_multiply_with_gradients.sv
// ----------------------------------------------------------------------------
// matrix_multiply_with_gradients: GEMM element queries with gradient modes
// Loads fill two operand RAMs; a query walks one dot product through them.
// ----------------------------------------------------------------------------
// Load word: written to its store at the accept edge.
// Query word: one read per cycle on each operand RAM, feeding the single MAC
//   unit, for len steps (len = active inner length, 1..MAX_DIM, or 0 for an
//   empty sum); an out-of-range query skips the walk. No new word is taken
//   until the result word is registered, so queries do not overlap.
// Reset: registers return to forward mode, 16x16x16; the RAMs are not cleared.
module matrix_multiply_with_gradients #(
  parameter int MAX_DIM = 16
) (
  input  logic                                clk,
  input  logic                                rst,
  // configuration write port
  input  logic                                cfg_we,
  input  logic [mmg_pkg::CFG_IDX_W-1:0]       cfg_index,
  input  logic [mmg_pkg::DIM_W-1:0]           cfg_data,
  // input words
  input  logic                                in_valid,
  output logic                                in_ready,
  input  logic [mmg_pkg::FUNC_W-1:0]          func,
  input  logic [mmg_pkg::IDX_W-1:0]           row,
  input  logic [mmg_pkg::IDX_W-1:0]           col,
  input  logic signed [mmg_pkg::ELEM_W-1:0]   elem_value,
  input  logic signed [mmg_pkg::VAL_W-1:0]    prior,
  // result words
  output logic                                out_valid,
  input  logic                                out_ready,
  output logic signed [mmg_pkg::VAL_W-1:0]    product_value,
  output logic                                saturated,
  output logic                                out_of_range
);

  localparam int DEPTH  = MAX_DIM * MAX_DIM;
  localparam int AW     = $clog2(DEPTH);
  localparam int TW     = $clog2(MAX_DIM);       // inner index bits
  localparam int LEN_W  = $clog2(MAX_DIM + 1);   // inner length, 0..MAX_DIM
  localparam int ACC_W  = mmg_pkg::VAL_W + TW + 2;

  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_RUN  = 2'd1;
  localparam logic [1:0] ST_DONE = 2'd2;

  // ---------------------------------------------------------------- config
  logic [mmg_pkg::MODE_W-1:0] op_mode;
  logic [mmg_pkg::DIM_W-1:0]  dim_m, dim_k, dim_n;

  always_ff @(posedge clk) begin
    if (rst) begin
      op_mode <= mmg_pkg::MODE_FWD;
      dim_m   <= mmg_pkg::DIM_RESET;
      dim_k   <= mmg_pkg::DIM_RESET;
      dim_n   <= mmg_pkg::DIM_RESET;
    end else if (cfg_we) begin
      case (cfg_index)
        mmg_pkg::CFG_OP_MODE: op_mode <= cfg_data[mmg_pkg::MODE_W-1:0];
        mmg_pkg::CFG_DIM_M:   dim_m   <= cfg_data;
        mmg_pkg::CFG_DIM_K:   dim_k   <= cfg_data;
        mmg_pkg::CFG_DIM_N:   dim_n   <= cfg_data;
        default: ;
      endcase
    end
  end

  // Dimensions above MAX_DIM clip to MAX_DIM.
  logic [LEN_W-1:0] m_eff, k_eff, n_eff;
  logic [LEN_W-1:0] rows_lim, cols_lim, len_sel;

  always_comb begin
    m_eff = (32'(dim_m) > MAX_DIM) ? LEN_W'(MAX_DIM) : LEN_W'(dim_m);
    k_eff = (32'(dim_k) > MAX_DIM) ? LEN_W'(MAX_DIM) : LEN_W'(dim_k);
    n_eff = (32'(dim_n) > MAX_DIM) ? LEN_W'(MAX_DIM) : LEN_W'(dim_n);
    case (op_mode)
      mmg_pkg::MODE_FWD: begin
        rows_lim = m_eff; cols_lim = n_eff; len_sel = k_eff;
      end
      mmg_pkg::MODE_GRAD_LEFT: begin
        rows_lim = m_eff; cols_lim = k_eff; len_sel = n_eff;
      end
      mmg_pkg::MODE_GRAD_RGHT: begin
        rows_lim = k_eff; cols_lim = n_eff; len_sel = m_eff;
      end
      default: begin
        // unused mode: empty shape, every query is out of range
        rows_lim = '0; cols_lim = '0; len_sel = '0;
      end
    endcase
  end

  // ------------------------------------------------------------ handshake
  logic [1:0] state;
  logic       in_acc, is_query, is_load, ld_in_store, q_oor_now;

  assign in_ready    = (state == ST_IDLE);
  assign in_acc      = in_valid && in_ready;
  assign is_query    = (func == mmg_pkg::FUNC_QUERY);
  assign is_load     = (func == mmg_pkg::FUNC_LOAD_FIRST) ||
                       (func == mmg_pkg::FUNC_LOAD_SECOND);
  assign ld_in_store = (32'(row) < MAX_DIM) && (32'(col) < MAX_DIM);
  assign q_oor_now   = (32'(row) >= 32'(rows_lim)) || (32'(col) >= 32'(cols_lim));

  // ------------------------------------------------------------ query regs
  logic [mmg_pkg::MODE_W-1:0] q_mode;
  logic [mmg_pkg::IDX_W-1:0]  q_row, q_col;
  logic [LEN_W-1:0]           q_len;
  logic                       q_oor;
  logic [LEN_W-1:0]           t;        // inner index being issued
  logic                       issue;    // read pair issued this cycle
  logic                       rd_valid; // RAM data valid this cycle

  assign issue = (state == ST_RUN) && (t < q_len);

  // ------------------------------------------------------------ store ports
  logic [AW-1:0]               waddr, raddr_a, raddr_b;
  logic [mmg_pkg::ELEM_W-1:0]  rdata_a, rdata_b;
  logic                        we_a, we_b;
  logic [31:0]                 a_r, a_c, b_r, b_c, t_ext;

  assign waddr = AW'(32'(row) * MAX_DIM + 32'(col));
  assign we_a  = in_acc && (func == mmg_pkg::FUNC_LOAD_FIRST) && ld_in_store;
  assign we_b  = in_acc && (func == mmg_pkg::FUNC_LOAD_SECOND) && ld_in_store;

  // Operand walk per mode:
  //   forward     first[row,t] * second[t,col]
  //   left grad   first[row,t] * second[col,t]
  //   right grad  first[t,row] * second[t,col]
  always_comb begin
    t_ext = 32'(t[TW-1:0]);
    a_r   = 32'(q_row);
    a_c   = t_ext;
    b_r   = t_ext;
    b_c   = 32'(q_col);
    case (q_mode)
      mmg_pkg::MODE_GRAD_LEFT: begin
        b_r = 32'(q_col);
        b_c = t_ext;
      end
      mmg_pkg::MODE_GRAD_RGHT: begin
        a_r = t_ext;
        a_c = 32'(q_row);
      end
      default: ;
    endcase
  end

  assign raddr_a = AW'(a_r * MAX_DIM + a_c);
  assign raddr_b = AW'(b_r * MAX_DIM + b_c);

  mmg_store #(.DEPTH(DEPTH), .AW(AW)) u_first (
    .clk   (clk),
    .we    (we_a),
    .waddr (waddr),
    .wdata (elem_value),
    .raddr (raddr_a),
    .rdata (rdata_a)
  );

  mmg_store #(.DEPTH(DEPTH), .AW(AW)) u_second (
    .clk   (clk),
    .we    (we_b),
    .waddr (waddr),
    .wdata (elem_value),
    .raddr (raddr_b),
    .rdata (rdata_b)
  );

  // ------------------------------------------------------------ MAC
  mmg_pkg::mac_ctrl_t             mac_ctrl;
  logic signed [mmg_pkg::VAL_W-1:0] mac_init, mac_result;
  logic                           mac_pending, mac_sat;

  // forward ignores the prior value
  assign mac_init       = (op_mode == mmg_pkg::MODE_FWD) ? '0 : prior;
  assign mac_ctrl.start = in_acc && is_query;
  assign mac_ctrl.step  = rd_valid;

  mmg_mac #(.ACC_W(ACC_W)) u_mac (
    .clk     (clk),
    .rst     (rst),
    .ctrl    (mac_ctrl),
    .init    (mac_init),
    .a       (rdata_a),
    .b       (rdata_b),
    .pending (mac_pending),
    .result  (mac_result),
    .sat     (mac_sat)
  );

  // ------------------------------------------------------------ sequencer
  logic [1:0] state_next;
  logic       out_load;

  // result register free, or being drained this cycle
  assign out_load = (state == ST_DONE) && (!out_valid || out_ready);

  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE: begin
        if (in_acc && is_query) begin
          state_next = q_oor_now ? ST_DONE : ST_RUN;
        end
      end
      ST_RUN: begin
        // all reads issued and drained through the MAC
        if (!issue && !rd_valid && !mac_pending) begin
          state_next = ST_DONE;
        end
      end
      ST_DONE: begin
        if (out_load) begin
          state_next = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= ST_IDLE;
      rd_valid <= 1'b0;
    end else begin
      state    <= state_next;
      rd_valid <= issue;
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc && is_query) begin
      q_mode <= op_mode;
      q_row  <= row;
      q_col  <= col;
      q_len  <= len_sel;
      q_oor  <= q_oor_now;
      t      <= '0;
    end else if (issue) begin
      t      <= t + LEN_W'(1);
    end
  end

  // ------------------------------------------------------------ result reg
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (out_load) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      product_value <= q_oor ? '0 : mac_result;
      saturated     <= q_oor ? 1'b0 : mac_sat;
      out_of_range  <= q_oor;
    end
  end

  // ------------------------------------------------------------ checks
  // reads are only issued by the walk
  a_rd_in_run: assert property (@(posedge clk) disable iff (rst)
    rd_valid |-> $past(state == ST_RUN))
    else $error("store read outside query walk");

  // a waiting result word is never overwritten
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    (state == ST_DONE && out_valid && !out_ready) |=> (state == ST_DONE))
    else $error("result word overwritten");

  // walk index stays within the inner length
  a_t_bound: assert property (@(posedge clk) disable iff (rst)
    (state == ST_RUN) |-> (t <= q_len))
    else $error("inner index past length");

  // new words only taken with the MAC pipeline empty
  a_idle_empty: assert property (@(posedge clk) disable iff (rst)
    in_ready |-> (!rd_valid && !mac_pending))
    else $error("word accepted with query in flight");

  // loads never drive both stores
  a_one_store: assert property (@(posedge clk) disable iff (rst)
    (we_a || we_b) |-> (is_load && !(we_a && we_b)))
    else $error("bad store write");

endmodule
